/* rtl/obb_overlap_test_defines.svh */
// Assertion macros for the box overlap test.
`ifndef OBB_OVERLAP_TEST_DEFINES_SVH
`define OBB_OVERLAP_TEST_DEFINES_SVH

// implication in the same cycle
`define OBB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lbl failed");

// implication in the next cycle
`define OBB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lbl failed");

`endif

/* rtl/obb_pkg.sv */
// Shared constants, types and helpers for the box overlap test.
package obb_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int COORD_EFF   = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
  localparam int SLOT_COUNT  = 10;
  localparam int AXIS_COUNT  = 15;
  localparam int BOX_AXES    = 6;
  localparam int CAND_W      = 34;
  localparam int EXT_W       = 17;
  localparam int PROD_W      = CAND_W + EXT_W;
  localparam int DOT_W       = PROD_W + 2;
  localparam int TERM_W      = 72;

  localparam logic [3:0] NO_AXIS   = 4'd15;
  localparam logic [3:0] LAST_AXIS = 4'd14;
  localparam logic [3:0] FIRST_CROSS = 4'd6;

  localparam logic [3:0] SLOT_A_CENTER = 4'd0;
  localparam logic [3:0] SLOT_A_SIZE   = 4'd1;
  localparam logic [3:0] SLOT_A_AXIS   = 4'd2;
  localparam logic [3:0] SLOT_B_CENTER = 4'd5;
  localparam logic [3:0] SLOT_B_SIZE   = 4'd6;
  localparam logic [3:0] SLOT_B_AXIS   = 4'd7;

  typedef logic [15:0] comp_t;
  typedef comp_t [2:0] vec_t;
  typedef logic signed [CAND_W-1:0] cand_comp_t;
  typedef cand_comp_t [2:0] cand_vec_t;
  typedef logic signed [EXT_W-1:0] ext_t;
  typedef ext_t [2:0] ext_vec_t;
  typedef logic signed [TERM_W-1:0] term_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] idx;
  } axis_tag_t;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN} state_t;

  // axis of A and of B for each candidate index (cross products only)
  localparam logic [1:0] CROSS_A [AXIS_COUNT] =
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
      2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
  localparam logic [1:0] CROSS_B [AXIS_COUNT] =
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
      2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

  function automatic ext_t sext_coord(input comp_t v);
    logic [COORD_EFF-1:0] low;
    low = v[COORD_EFF-1:0];
    return $signed({{(EXT_W-COORD_EFF){low[COORD_EFF-1]}}, low});
  endfunction

  function automatic ext_t sext_axis(input comp_t v);
    return $signed({v[15], v});
  endfunction

endpackage

/* rtl/obb_cand.sv */
// Candidate axis generator: box axes scaled to Q2.28 or cross products.
module obb_cand
  import obb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  axis_tag_t tag_in,
  input  vec_t      axis_a [3],
  input  vec_t      axis_b [3],
  input  vec_t      center_a,
  input  vec_t      center_b,
  output axis_tag_t tag_out,
  output cand_vec_t cand_out,
  output ext_vec_t  t_out
);

  axis_tag_t tag_r;
  cand_vec_t cand_r, cand_nxt;
  ext_vec_t  t_r, t_nxt;
  vec_t      box_sel, xa, xb;
  logic signed [31:0] p0, p1, p2, p3, p4, p5;

  always_comb begin
    if (tag_in.idx < 4'd3) begin
      box_sel = axis_a[tag_in.idx[1:0]];
    end else begin
      box_sel = axis_b[2'(tag_in.idx - 4'd3)];
    end
    xa = axis_a[CROSS_A[tag_in.idx]];
    xb = axis_b[CROSS_B[tag_in.idx]];
    p0 = $signed(xa[1]) * $signed(xb[2]);
    p1 = $signed(xa[2]) * $signed(xb[1]);
    p2 = $signed(xa[2]) * $signed(xb[0]);
    p3 = $signed(xa[0]) * $signed(xb[2]);
    p4 = $signed(xa[0]) * $signed(xb[1]);
    p5 = $signed(xa[1]) * $signed(xb[0]);
    if (tag_in.idx < FIRST_CROSS) begin
      for (int k = 0; k < 3; k++) begin
        cand_nxt[k] = $signed({{(CAND_W-30){box_sel[k][15]}}, box_sel[k], 14'b0});
      end
    end else begin
      cand_nxt[0] = CAND_W'(p0) - CAND_W'(p1);
      cand_nxt[1] = CAND_W'(p2) - CAND_W'(p3);
      cand_nxt[2] = CAND_W'(p4) - CAND_W'(p5);
    end
    for (int k = 0; k < 3; k++) begin
      t_nxt[k] = sext_coord(center_b[k]) - sext_coord(center_a[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
    cand_r <= cand_nxt;
    t_r    <= t_nxt;
  end

  assign tag_out  = tag_r;
  assign cand_out = cand_r;
  assign t_out    = t_r;

endmodule

/* rtl/obb_lane.sv */
// Projection lane: scale * |dot(candidate, vector)| over two stages.
module obb_lane
  import obb_pkg::*;
(
  input  logic      clk,
  input  cand_vec_t cand,
  input  ext_vec_t  vec,
  input  ext_t      scale,
  output term_t     term
);

  logic signed [PROD_W-1:0] p0, p1, p2;
  logic signed [DOT_W-1:0]  dot_r, dot_nxt, mag;
  ext_t  scale_r;
  term_t term_r, term_nxt;

  always_comb begin
    p0 = cand[0] * vec[0];
    p1 = cand[1] * vec[1];
    p2 = cand[2] * vec[2];
    dot_nxt = DOT_W'(p0) + DOT_W'(p1) + DOT_W'(p2);
    mag = dot_r[DOT_W-1] ? -dot_r : dot_r;
    term_nxt = $signed({1'b0, mag}) * scale_r;
  end

  always_ff @(posedge clk) begin
    dot_r   <= dot_nxt;
    scale_r <= scale;
    term_r  <= term_nxt;
  end

  assign term = term_r;

endmodule

/* rtl/obb_merge.sv */
// Merge stage: sums lane terms, compares, keeps the first separating axis.
module obb_merge
  import obb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      clear,
  input  axis_tag_t tag_in,
  input  term_t     dist_in,
  input  term_t     terms [BOX_AXES],
  output logic      res_valid,
  output logic      res_overlap,
  output logic [3:0] res_axis
);

  axis_tag_t tag_a_r, tag_b_r;
  term_t dist_a_r, s0_r, s1_r, s2_r;
  logic sep_r, sep_nxt;
  logic found_r;
  logic [3:0] axis_r;
  logic valid_r, overlap_r;
  logic [3:0] res_axis_r;

  assign sep_nxt = dist_a_r > (s0_r + s1_r + s2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
      found_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      tag_a_r <= tag_in;
      tag_b_r <= tag_a_r;
      valid_r <= 1'b0;
      if (clear) begin
        found_r <= 1'b0;
      end else if (tag_b_r.valid && sep_r && !found_r) begin
        found_r <= 1'b1;
      end
      if (tag_b_r.valid && tag_b_r.idx == LAST_AXIS) begin
        valid_r <= 1'b1;
      end
    end
    dist_a_r <= dist_in;
    s0_r <= terms[0] + terms[1];
    s1_r <= terms[2] + terms[3];
    s2_r <= terms[4] + terms[5];
    sep_r <= sep_nxt;
    if (tag_b_r.valid && sep_r && !found_r) begin
      axis_r <= tag_b_r.idx;
    end
    overlap_r  <= !(found_r || sep_r);
    res_axis_r <= found_r ? axis_r : (sep_r ? tag_b_r.idx : NO_AXIS);
  end

  assign res_valid   = valid_r;
  assign res_overlap = overlap_r;
  assign res_axis    = res_axis_r;

endmodule

/* rtl/obb_overlap_test.sv */
// Top level of the oriented box overlap test.
// Usage:
//   Input: a transaction is taken on a rising edge with start high and busy
//   low. in_slot picks one of ten vectors (A center, size, three axes, then
//   the same for B); in_comp_x/y/z are written there. Slots above nine write
//   nothing. A load without in_evaluate leaves busy low.
//   With in_evaluate set the vector is stored, then the 15 candidate axes are
//   issued one per cycle into seven projection lanes (one for the center
//   offset, six for the box axes) and a merge stage that sums and compares.
//   The result is registered through the candidate register, the lane dot
//   and term registers and the merge sum, compare and result registers;
//   busy stays high up to and including the result cycle, so the next
//   transaction is taken only after the axis issue and this pipeline end.
//   Output: out_valid strobes for one cycle with out_overlap and
//   out_separating_axis (first separating axis, 15 when overlapping). The
//   receiver cannot stall; the result must be taken in that cycle.
//   Reset: rst_n low clears control; the vector store is undefined until
//   written, and each slot must be loaded before a test reads it.
module obb_overlap_test
  import obb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [3:0] in_slot,
  input  logic signed [15:0] in_comp_x,
  input  logic signed [15:0] in_comp_y,
  input  logic signed [15:0] in_comp_z,
  input  logic       in_evaluate,
  output logic       out_valid,
  output logic       out_overlap,
  output logic [3:0] out_separating_axis
);

  vec_t store_r [SLOT_COUNT];
  vec_t axis_a [3];
  vec_t axis_b [3];
  state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic accept, clear;
  axis_tag_t issue_tag, cand_tag, tag_d1_r, tag_d2_r;
  cand_vec_t cand;
  ext_vec_t  t_vec;
  term_t     dist_term;
  term_t     terms [BOX_AXES];
  ext_vec_t  box_vec [BOX_AXES];
  ext_t      box_size [BOX_AXES];

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept && in_slot < 4'(SLOT_COUNT)) begin
      store_r[in_slot] <= {comp_t'(in_comp_z), comp_t'(in_comp_y), comp_t'(in_comp_x)};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      axis_a[i] = store_r[SLOT_A_AXIS + 4'(i)];
      axis_b[i] = store_r[SLOT_B_AXIS + 4'(i)];
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        box_vec[i][k]     = sext_axis(axis_a[i][k]);
        box_vec[i + 3][k] = sext_axis(axis_b[i][k]);
      end
      box_size[i]     = sext_coord(store_r[SLOT_A_SIZE][i]);
      box_size[i + 3] = sext_coord(store_r[SLOT_B_SIZE][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      tag_d1_r <= '0;
      tag_d2_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      tag_d1_r <= cand_tag;
      tag_d2_r <= tag_d1_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    clear     = 1'b0;
    issue_tag = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start && in_evaluate) begin
          state_nxt = ST_ISSUE;
          cnt_nxt   = '0;
          clear     = 1'b1;
        end
      end
      ST_ISSUE: begin
        issue_tag.valid = 1'b1;
        issue_tag.idx   = cnt_r;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == LAST_AXIS) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_valid) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  obb_cand u_cand (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (issue_tag),
    .axis_a   (axis_a),
    .axis_b   (axis_b),
    .center_a (store_r[SLOT_A_CENTER]),
    .center_b (store_r[SLOT_B_CENTER]),
    .tag_out  (cand_tag),
    .cand_out (cand),
    .t_out    (t_vec)
  );

  obb_lane u_lane_dist (
    .clk   (clk),
    .cand  (cand),
    .vec   (t_vec),
    .scale (ext_t'(32768)),
    .term  (dist_term)
  );

  for (genvar g = 0; g < BOX_AXES; g++) begin : g_lane
    obb_lane u_lane (
      .clk   (clk),
      .cand  (cand),
      .vec   (box_vec[g]),
      .scale (box_size[g]),
      .term  (terms[g])
    );
  end

  obb_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (clear),
    .tag_in      (tag_d2_r),
    .dist_in     (dist_term),
    .terms       (terms),
    .res_valid   (out_valid),
    .res_overlap (out_overlap),
    .res_axis    (out_separating_axis)
  );

endmodule

/* rtl/obb_chk.sv */
// Port-level checker for the box overlap test, bound to the top level.
`include "obb_overlap_test_defines.svh"

module obb_chk
  import obb_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_evaluate,
  input logic       out_valid,
  input logic       out_overlap,
  input logic [3:0] out_separating_axis
);

  `OBB_ASSERT_IMP(a_result_while_busy, clk, rst_n, out_valid, busy)
  `OBB_ASSERT_IMP(a_flag_axis, clk, rst_n, out_valid, out_overlap == (out_separating_axis == NO_AXIS))
  `OBB_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid && !busy)
  `OBB_ASSERT_NXT(a_load_stays_free, clk, rst_n, start && !busy && !in_evaluate, !busy && !out_valid)
  `OBB_ASSERT_NXT(a_test_goes_busy, clk, rst_n, start && !busy && in_evaluate, busy)

endmodule

bind obb_overlap_test obb_chk u_obb_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_evaluate         (in_evaluate),
  .out_valid           (out_valid),
  .out_overlap         (out_overlap),
  .out_separating_axis (out_separating_axis)
);
